/* src/csem_pkg.sv */
// shared types and constants for the collective spin step core
package csem_pkg;

    // spin and gain word width (Q3.12 spins, 16-bit gains)
    localparam int Q_W = 16;
    // collective sum width, enough for 64 atoms of 16 bits
    localparam int SUM_W = 22;
    // noise gain times noise increment
    localparam int ND_W = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_GAIN = 2'd1;

    // reset value of the noise gain, 1.0 in Q4.12
    localparam logic [Q_W-1:0] NOISE_GAIN_RST = 16'd4096;

    // one atom's spin triple
    typedef struct packed {
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
    } t_spin;

    // values held for one run of the update pipeline
    typedef struct packed {
        logic signed [SUM_W-1:0] jx;
        logic signed [SUM_W-1:0] jy;
        logic signed [ND_W-1:0]  ndp;
        logic signed [ND_W-1:0]  ndq;
    } t_run_par;

endpackage

/* src/csem_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module csem_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/csem_dp.sv */
// five-stage update pipeline: products, brackets, gain, sum, round and saturate
module csem_dp import csem_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_v,
    input  logic           i_eor,
    input  t_spin          i_spin,
    input  t_run_par       i_run,
    input  logic [Q_W-1:0] i_drift_gain,
    output logic           o_valid,
    output logic           o_busy,
    output t_spin          o_res,
    output logic           o_eor
);

    // round a 2^-40 value half up to Q3.12 and saturate
    function automatic logic signed [Q_W-1:0] round_sat(input logic signed [59:0] v);
        logic signed [59:0] t;
        logic signed [31:0] q;
        logic signed [Q_W-1:0] r;
        t = v + 60'sd134217728;
        q = t[59:28];
        if (q > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (q < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = q[Q_W-1:0];
        end
        return r;
    endfunction

    logic [5:1] r_v;
    logic [5:1] r_eor;

    // stage 1 registers
    t_spin              r_s1_spin;
    logic signed [37:0] r_s1_jxz, r_s1_jyz, r_s1_jxx, r_s1_jyy;
    logic signed [32:0] r_s1_xzp, r_s1_yzp;
    logic signed [31:0] r_s1_xx, r_s1_yy;
    logic signed [47:0] r_s1_nzp, r_s1_nzq, r_s1_nxp, r_s1_nyq;
    // stage 2 registers
    t_spin              r_s2_spin;
    logic signed [39:0] r_s2_bx, r_s2_by, r_s2_bz;
    logic signed [48:0] r_s2_wx, r_s2_wy, r_s2_wz;
    // stage 3 registers
    t_spin              r_s3_spin;
    logic signed [56:0] r_s3_gbx, r_s3_gby, r_s3_gbz;
    logic signed [48:0] r_s3_wx, r_s3_wy, r_s3_wz;
    // stage 4 registers
    logic signed [59:0] r_s4_vx, r_s4_vy, r_s4_vz;
    // stage 5 registers
    t_spin              r_s5_res;

    logic signed [Q_W:0] w_zp1;
    logic signed [Q_W:0] w_g;

    assign w_zp1 = $signed({i_spin.z[Q_W-1], i_spin.z}) + 17'sd4096;
    assign w_g   = $signed({1'b0, i_drift_gain});

    // stage valids and end-of-run flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_eor <= '0;
        end else if (i_adv) begin
            r_v   <= {r_v[4:1], i_v};
            r_eor <= {r_eor[4:1], i_eor};
        end
    end

    // datapath, whole pipe moves together
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // products of old spins with sums and noise
            r_s1_spin <= i_spin;
            r_s1_jxz  <= i_run.jx * i_spin.z;
            r_s1_jyz  <= i_run.jy * i_spin.z;
            r_s1_xzp  <= i_spin.x * w_zp1;
            r_s1_yzp  <= i_spin.y * w_zp1;
            r_s1_jxx  <= i_run.jx * i_spin.x;
            r_s1_jyy  <= i_run.jy * i_spin.y;
            r_s1_xx   <= i_spin.x * i_spin.x;
            r_s1_yy   <= i_spin.y * i_spin.y;
            r_s1_nzp  <= i_spin.z * i_run.ndp;
            r_s1_nzq  <= i_spin.z * i_run.ndq;
            r_s1_nxp  <= i_spin.x * i_run.ndp;
            r_s1_nyq  <= i_spin.y * i_run.ndq;

            // drift brackets and diffusion terms
            r_s2_spin <= r_s1_spin;
            r_s2_bx   <= 40'(r_s1_jxz) - 40'(r_s1_xzp);
            r_s2_by   <= 40'(r_s1_jyz) - 40'(r_s1_yzp);
            r_s2_bz   <= (40'(r_s1_spin.z) <<< 13) + 40'sd33554432
                         + 40'(r_s1_jxx) + 40'(r_s1_jyy)
                         - 40'(r_s1_xx) - 40'(r_s1_yy);
            r_s2_wx   <= -49'(r_s1_nzp);
            r_s2_wy   <= 49'(r_s1_nzq);
            r_s2_wz   <= 49'(r_s1_nxp) - 49'(r_s1_nyq);

            // drift gain
            r_s3_spin <= r_s2_spin;
            r_s3_gbx  <= w_g * r_s2_bx;
            r_s3_gby  <= w_g * r_s2_by;
            r_s3_gbz  <= w_g * r_s2_bz;
            r_s3_wx   <= r_s2_wx;
            r_s3_wy   <= r_s2_wy;
            r_s3_wz   <= r_s2_wz;

            // full value at scale 2^-40
            r_s4_vx <= (60'(r_s3_spin.x) <<< 28) + 60'(r_s3_gbx) + (60'(r_s3_wx) <<< 4);
            r_s4_vy <= (60'(r_s3_spin.y) <<< 28) + 60'(r_s3_gby) + (60'(r_s3_wy) <<< 4);
            r_s4_vz <= (60'(r_s3_spin.z) <<< 28) - 60'(r_s3_gbz) + (60'(r_s3_wz) <<< 4);

            // round and saturate into the output register
            r_s5_res.x <= round_sat(r_s4_vx);
            r_s5_res.y <= round_sat(r_s4_vy);
            r_s5_res.z <= round_sat(r_s4_vz);
        end
    end

    assign o_valid = r_v[5];
    assign o_busy  = |r_v;
    assign o_res   = r_s5_res;
    assign o_eor   = r_eor[5];

endmodule

/* src/collective_spin_euler_maruyama_step_core.sv */
// top level of the collective spin euler-maruyama step core
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-----------------------------------
//  in      | to core   | i_in_valid / o_in_ready     | spin x/y/z, noise q/p, last_atom
//  out     | from core | o_out_valid / i_out_ready   | new x/y/z, end_of_run
//  cfg     | to core   | i_cfg_we (no wait)          | i_cfg_addr, i_cfg_wdata
//
// atoms load back to back: each transaction writes one spin store entry while the
// store has room. after the last atom the store is read one entry per cycle, while the
// output is not stalled, into a five-stage update pipeline.
// input is held off from the last transaction until the final result is taken.
// reset is synchronous and needs no clearing pass; only entries of the current run are read.
// a stalled output freezes the whole update pipeline and the store read.
module collective_spin_euler_maruyama_step_core import csem_pkg::*; #(
    parameter int MAX_ATOMS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input transactions
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [Q_W-1:0] i_spin_x,
    input  logic signed [Q_W-1:0] i_spin_y,
    input  logic signed [Q_W-1:0] i_spin_z,
    input  logic signed [Q_W-1:0] i_noise_q,
    input  logic signed [Q_W-1:0] i_noise_p,
    input  logic                  i_last_atom,
    // output transactions
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [Q_W-1:0] o_new_x,
    output logic signed [Q_W-1:0] o_new_y,
    output logic signed [Q_W-1:0] o_new_z,
    output logic                  o_end_of_run,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [Q_W-1:0]        i_cfg_wdata
);

    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CW = $clog2(MAX_ATOMS + 1);

    logic [Q_W-1:0]          r_drift_gain;
    logic [Q_W-1:0]          r_noise_gain;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y;
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           r_run_cnt;
    logic [CW-1:0]           r_rd_idx;
    logic                    r_emit;
    logic                    r_v0;
    logic                    r_eor0;
    t_run_par                r_run;

    logic                    w_in_acc;
    logic                    w_room;
    logic                    w_adv;
    logic                    w_rd_last;
    logic signed [SUM_W-1:0] w_sum_x, w_sum_y;
    logic signed [Q_W:0]     w_ng;
    logic signed [ND_W-1:0]  w_ndp, w_ndq;
    t_spin                   w_wr_spin;
    t_spin                   w_rd_spin;
    t_spin                   w_res;
    logic                    w_dp_valid;
    logic                    w_dp_busy;
    logic                    w_dp_eor;

    // handshake and pipeline advance
    assign o_in_ready = !r_emit && !r_v0 && !w_dp_busy;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_adv      = !w_dp_valid || i_out_ready;
    assign w_room     = r_cnt < CW'(MAX_ATOMS);
    assign w_rd_last  = (r_rd_idx + CW'(1)) == r_run_cnt;

    // collective sums including the current atom when it is stored
    assign w_sum_x = r_sum_x + (w_room ? SUM_W'(i_spin_x) : '0);
    assign w_sum_y = r_sum_y + (w_room ? SUM_W'(i_spin_y) : '0);

    // diffusion gain times the two noise increments
    assign w_ng  = $signed({1'b0, r_noise_gain});
    assign w_ndp = w_ng * i_noise_p;
    assign w_ndq = w_ng * i_noise_q;

    assign w_wr_spin.x = i_spin_x;
    assign w_wr_spin.y = i_spin_y;
    assign w_wr_spin.z = i_spin_z;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drift_gain <= '0;
            r_noise_gain <= NOISE_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DRIFT_GAIN: r_drift_gain <= i_cfg_wdata;
                REG_NOISE_GAIN: r_noise_gain <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // load phase: count, sums, and run latch on the last atom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_cnt     <= '0;
            r_run_cnt <= '0;
        end else if (w_in_acc) begin
            if (i_last_atom) begin
                r_sum_x   <= '0;
                r_sum_y   <= '0;
                r_cnt     <= '0;
                r_run_cnt <= w_room ? r_cnt + CW'(1) : r_cnt;
            end else if (w_room) begin
                r_sum_x <= w_sum_x;
                r_sum_y <= w_sum_y;
                r_cnt   <= r_cnt + CW'(1);
            end
        end
    end

    // run values used by the product stage for the whole run
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_last_atom) begin
            r_run.jx  <= w_sum_x;
            r_run.jy  <= w_sum_y;
            r_run.ndp <= w_ndp;
            r_run.ndq <= w_ndq;
        end
    end

    // emit phase: walk the store one entry per advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit   <= 1'b0;
            r_rd_idx <= '0;
            r_v0     <= 1'b0;
            r_eor0   <= 1'b0;
        end else begin
            if (w_in_acc && i_last_atom) begin
                r_emit   <= 1'b1;
                r_rd_idx <= '0;
            end else if (r_emit && w_adv) begin
                r_rd_idx <= r_rd_idx + CW'(1);
                if (w_rd_last) begin
                    r_emit <= 1'b0;
                end
            end
            if (w_adv) begin
                r_v0   <= r_emit;
                r_eor0 <= r_emit && w_rd_last;
            end
        end
    end

    // spin store
    csem_ram #(
        .WIDTH ($bits(t_spin)),
        .DEPTH (MAX_ATOMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_room),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_wr_spin),
        .i_re    (r_emit && w_adv),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rd_spin)
    );

    // update pipeline
    csem_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_v          (r_v0),
        .i_eor        (r_eor0),
        .i_spin       (w_rd_spin),
        .i_run        (r_run),
        .i_drift_gain (r_drift_gain),
        .o_valid      (w_dp_valid),
        .o_busy       (w_dp_busy),
        .o_res        (w_res),
        .o_eor        (w_dp_eor)
    );

    assign o_out_valid  = w_dp_valid;
    assign o_new_x      = w_res.x;
    assign o_new_y      = w_res.y;
    assign o_new_z      = w_res.z;
    assign o_end_of_run = w_dp_eor;

endmodule

/* src/csem_chk.sv */
// port-level checks for the collective spin step core, with bind
module csem_chk import csem_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  i_last_atom,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic signed [Q_W-1:0] o_new_x,
    input logic signed [Q_W-1:0] o_new_y,
    input logic signed [Q_W-1:0] o_new_z,
    input logic                  o_end_of_run
);

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    // a last atom starts the emit run and closes the input
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_atom) |=> !o_in_ready)
        else $error("input ready right after last atom");

    // input stays closed after a taken result that is not the end of run
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_end_of_run) |=> !o_in_ready)
        else $error("input reopened before end of run");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_new_x) && $stable(o_new_y) && $stable(o_new_z)
         && $stable(o_end_of_run)))
        else $error("stalled result changed");

endmodule

bind collective_spin_euler_maruyama_step_core csem_chk u_csem_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_last_atom  (i_last_atom),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_new_x      (o_new_x),
    .o_new_y      (o_new_y),
    .o_new_z      (o_new_z),
    .o_end_of_run (o_end_of_run)
);
